// ===== src/mfd_pkg.sv =====
// mfd_pkg: section codes and fixed field widths for the message frame deframer
// no dependencies; imported by message_frame_deframer_top
package mfd_pkg;

    // message sections in wire order
    typedef enum logic [2:0] {
        SEC_SEQ_HI  = 3'd0,
        SEC_SEQ_LO  = 3'd1,
        SEC_TYPE    = 3'd2,
        SEC_SRV_KEY = 3'd3,
        SEC_CLI_KEY = 3'd4,
        SEC_LENGTH  = 3'd5,
        SEC_PAYLOAD = 3'd6,
        SEC_HASH    = 3'd7
    } t_section;

    localparam int CNT_W      = 13;  // byte counter and payload length
    localparam int LIMIT_W    = 13;  // payload limit register
    localparam int OFFSET_W   = 12;  // reported byte offset
    localparam int BYTE_W     = 8;
    localparam int VALUE_W    = 64;
    localparam int LEN_W      = 32;  // length field on the wire
    localparam int VALUE_LANES = VALUE_W / BYTE_W;

    localparam logic [CNT_W-1:0]   SEQ_BYTES     = 13'd8;
    localparam logic [CNT_W-1:0]   TYPE_BYTES    = 13'd4;
    localparam logic [CNT_W-1:0]   LEN_BYTES     = 13'd4;
    localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 13'd4096;

endpackage

// ===== src/message_frame_deframer_top.sv =====
// message_frame_deframer_top: byte-wise message deframer with section tagging
// depends on mfd_pkg (section codes and field widths)
//
// path: each input transaction passes through the input register and then the result register
//   on its way to its result transaction; one result transaction per input
// throughput: one byte per cycle while i_stall is low, set by the single section/offset counter update
// reset (synchronous, active low): parser at start of high sequence, counters and
//   value cleared, payload limit 4096, both pipeline stages empty
module message_frame_deframer_top #(
    parameter int KEY_BYTES   = 32,
    parameter int MAX_PAYLOAD = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [mfd_pkg::LIMIT_W-1:0]       i_cfg_data,
    // byte input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [mfd_pkg::BYTE_W-1:0]        i_data_byte,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output mfd_pkg::t_section                 o_section,
    output logic [mfd_pkg::OFFSET_W-1:0]      o_byte_offset,
    output logic [mfd_pkg::BYTE_W-1:0]        o_byte_out,
    output logic                              o_section_end,
    output logic                              o_frame_end,
    output logic                              o_length_error,
    output logic [mfd_pkg::VALUE_W-1:0]       o_field_value
);
    import mfd_pkg::*;

    localparam logic [CNT_W-1:0]   KEY_SIZE = CNT_W'(KEY_BYTES);
    localparam logic [LIMIT_W-1:0] MAX_PL   = LIMIT_W'(MAX_PAYLOAD);

    // configuration
    logic [LIMIT_W-1:0] r_payload_limit;

    // input register
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;

    // parser state
    t_section           r_section,     n_section;
    logic [CNT_W-1:0]   r_bytes_taken, n_bytes_taken;
    logic [CNT_W-1:0]   r_payload_len, n_payload_len;
    logic [VALUE_W-1:0] r_acc,         n_acc;

    // result register
    logic               r_out_valid;
    t_section           r_o_section;
    logic [OFFSET_W-1:0] r_o_offset;
    logic [BYTE_W-1:0]  r_o_byte;
    logic               r_o_sec_end;
    logic               r_o_frame_end;
    logic               r_o_len_err;
    logic [VALUE_W-1:0] r_o_value;

    // per-byte decode
    logic               advance;
    logic               in_accept;
    logic [CNT_W-1:0]   sec_size;
    logic [CNT_W:0]     off_plus;
    logic               last;
    logic               numeric;
    logic [VALUE_W-1:0] acc_upd;
    logic [LIMIT_W-1:0] eff_limit;
    logic [LEN_W-1:0]   len_word;
    logic               len_err;
    logic               frame_end;
    logic [VALUE_W-1:0] res_value;

    // handshakes: the input register frees up whenever its byte moves on
    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    // section size and end detection
    always_comb begin
        unique case (r_section)
            SEC_SEQ_HI, SEC_SEQ_LO:             sec_size = SEQ_BYTES;
            SEC_TYPE:                           sec_size = TYPE_BYTES;
            SEC_LENGTH:                         sec_size = LEN_BYTES;
            SEC_SRV_KEY, SEC_CLI_KEY, SEC_HASH: sec_size = KEY_SIZE;
            SEC_PAYLOAD:                        sec_size = r_payload_len;
            default:                            sec_size = r_payload_len;
        endcase
    end

    assign off_plus = {1'b0, r_bytes_taken} + (CNT_W+1)'(1);
    // a zero size, or a counter at or past the size minus one, marks the last byte
    assign last     = (sec_size == '0) || (off_plus >= {1'b0, sec_size});
    assign numeric  = (r_section == SEC_SEQ_HI) || (r_section == SEC_SEQ_LO) ||
                      (r_section == SEC_TYPE)   || (r_section == SEC_LENGTH);

    // little-endian accumulation, one byte lane per offset
    always_comb begin
        acc_upd = r_acc;
        for (int k = 0; k < VALUE_LANES; k++) begin
            if (numeric && r_bytes_taken == CNT_W'(k)) begin
                acc_upd[k*BYTE_W +: BYTE_W] = r_acc[k*BYTE_W +: BYTE_W] | r_in_byte;
            end
        end
    end

    // limit saturates at the build-time maximum
    assign eff_limit = (r_payload_limit > MAX_PL) ? MAX_PL : r_payload_limit;
    assign len_word  = acc_upd[LEN_W-1:0];
    assign len_err   = last && (r_section == SEC_LENGTH) &&
                       (len_word > LEN_W'(eff_limit));
    assign frame_end = last && (r_section == SEC_HASH);

    // reported value: zero outside numeric sections, else the running value, or the 32-bit length at the length end
    always_comb begin
        if (!numeric) begin
            res_value = '0;
        end else if (last && r_section == SEC_LENGTH) begin
            res_value = VALUE_W'(len_word);
        end else begin
            res_value = acc_upd;
        end
    end

    // next parser state
    always_comb begin
        n_section     = r_section;
        n_bytes_taken = off_plus[CNT_W-1:0];
        n_payload_len = r_payload_len;
        n_acc         = acc_upd;
        if (last) begin
            n_bytes_taken = '0;
            n_acc         = '0;
            unique case (r_section)
                SEC_LENGTH: begin
                    if (len_err) begin
                        n_section     = SEC_SEQ_HI;
                        n_payload_len = '0;
                    end else begin
                        n_payload_len = len_word[CNT_W-1:0];
                        n_section     = (len_word == '0) ? SEC_HASH : SEC_PAYLOAD;
                    end
                end
                SEC_HASH: begin
                    n_section = SEC_SEQ_HI;
                end
                default: begin
                    n_section = t_section'(3'(r_section + 3'd1));
                end
            endcase
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_limit <= LIMIT_DEFAULT;
        end else if (i_cfg_we) begin
            r_payload_limit <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    // parser state, stepped once per byte leaving the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section     <= SEC_SEQ_HI;
            r_bytes_taken <= '0;
            r_payload_len <= '0;
            r_acc         <= '0;
        end else if (advance) begin
            r_section     <= n_section;
            r_bytes_taken <= n_bytes_taken;
            r_payload_len <= n_payload_len;
            r_acc         <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_section   <= r_section;
            r_o_offset    <= r_bytes_taken[OFFSET_W-1:0];
            r_o_byte      <= r_in_byte;
            r_o_sec_end   <= last;
            r_o_frame_end <= frame_end;
            r_o_len_err   <= len_err;
            r_o_value     <= res_value;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_section      = r_o_section;
    assign o_byte_offset  = r_o_offset;
    assign o_byte_out     = r_o_byte;
    assign o_section_end  = r_o_sec_end;
    assign o_frame_end    = r_o_frame_end;
    assign o_length_error = r_o_len_err;
    assign o_field_value  = r_o_value;

    // a frame only ends on the closing byte of the hash
    a_frame_end_on_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_frame_end) |-> (r_o_sec_end && r_o_section == SEC_HASH))
        else $error("frame end outside hash section end");

    // a length error closes the length section and restarts the parser
    a_len_err_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && len_err) |=> (r_section == SEC_SEQ_HI && r_bytes_taken == '0))
        else $error("length error did not restart parser");

    // every section boundary clears the offset and the running value
    a_section_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && last) |=> (r_bytes_taken == '0 && r_acc == '0))
        else $error("section boundary left stale counter or value");

    // non-numeric sections report no value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_section == SEC_SRV_KEY || r_o_section == SEC_CLI_KEY ||
                         r_o_section == SEC_PAYLOAD || r_o_section == SEC_HASH))
        |-> (r_o_value == '0))
        else $error("value reported for non-numeric section");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for message_frame_deframer_top, byte stream in, tagged bytes out
// depends on mfd_pkg and message_frame_deframer_top; predicts every result transaction in-line
module tb;
    import mfd_pkg::*;

    localparam int KEY_LEN        = 32;
    localparam int MAX_LEN        = 4096;
    localparam int TOTAL_ITEMS    = 850;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 40;

    // expected tag for one byte
    typedef struct {
        t_section             section;
        logic [OFFSET_W-1:0]  offset;
        logic [BYTE_W-1:0]    data;
        logic                 sec_end;
        logic                 frm_end;
        logic                 len_err;
        logic [VALUE_W-1:0]   value;
    } t_byte_tag;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0]    i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_section              o_section;
    logic [OFFSET_W-1:0]   o_byte_offset;
    logic [BYTE_W-1:0]     o_byte_out;
    logic                  o_section_end;
    logic                  o_frame_end;
    logic                  o_length_error;
    logic [VALUE_W-1:0]    o_field_value;

    message_frame_deframer_top #(
        .KEY_BYTES   (KEY_LEN),
        .MAX_PAYLOAD (MAX_LEN)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_section      (o_section),
        .o_byte_offset  (o_byte_offset),
        .o_byte_out     (o_byte_out),
        .o_section_end  (o_section_end),
        .o_frame_end    (o_frame_end),
        .o_length_error (o_length_error),
        .o_field_value  (o_field_value)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // bytes waiting to be driven, and tags waiting for their result transaction
    logic [BYTE_W-1:0] stream_q[$];
    t_byte_tag         tag_q[$];

    // parser state mirrored by the predictor, reset values
    t_section           cur_sec   = SEC_SEQ_HI;
    logic [CNT_W-1:0]   taken     = '0;
    logic [CNT_W-1:0]   pay_len   = '0;
    logic [VALUE_W-1:0] acc       = '0;
    logic [LIMIT_W-1:0] limit_reg = LIMIT_DEFAULT;

    // run statistics
    int errors       = 0;
    int checked      = 0;
    int frames_seen  = 0;
    int len_errs     = 0;
    int queued       = 0;
    int settings     = 1;
    int idle_cycles  = 0;

    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;

    // limit above the maximum payload saturates
    function automatic logic [LIMIT_W-1:0] eff_limit();
        return (limit_reg > LIMIT_W'(MAX_LEN)) ? LIMIT_W'(MAX_LEN) : limit_reg;
    endfunction

    function automatic logic [CNT_W-1:0] section_bytes(t_section s);
        case (s)
            SEC_SEQ_HI, SEC_SEQ_LO: return SEQ_BYTES;
            SEC_TYPE:               return TYPE_BYTES;
            SEC_LENGTH:             return LEN_BYTES;
            SEC_PAYLOAD:            return pay_len;
            default:                return CNT_W'(KEY_LEN);
        endcase
    endfunction

    function automatic void open_section(t_section s);
        cur_sec = s;
        taken   = '0;
        acc     = '0;
    endfunction

    // advance the mirrored parser by one byte and return the tag it should carry
    function automatic t_byte_tag deframe_byte(logic [BYTE_W-1:0] b);
        t_byte_tag        r;
        logic [CNT_W-1:0] size;
        logic [LEN_W-1:0] len;
        logic             numeric;
        logic             last;
        r.section = cur_sec;
        r.offset  = taken[OFFSET_W-1:0];
        r.data    = b;
        r.frm_end = 1'b0;
        r.len_err = 1'b0;
        r.value   = '0;
        size      = section_bytes(cur_sec);
        // an empty section still closes on its first byte
        last      = (size == 0) || ({1'b0, taken} + 14'd1 >= {1'b0, size});
        numeric   = (cur_sec == SEC_SEQ_HI) || (cur_sec == SEC_SEQ_LO) ||
                    (cur_sec == SEC_TYPE) || (cur_sec == SEC_LENGTH);
        if (numeric) begin
            if (taken < 8)
                acc = acc | (VALUE_W'(b) << (8 * taken));
            r.value = acc;
        end
        if (!last) begin
            taken = taken + 1'b1;
        end else if (cur_sec == SEC_LENGTH) begin
            len     = acc[LEN_W-1:0];
            r.value = VALUE_W'(len);
            if (len > LEN_W'(eff_limit())) begin
                // oversize length drops the message and restarts
                r.len_err = 1'b1;
                pay_len   = '0;
                open_section(SEC_SEQ_HI);
            end else begin
                pay_len = len[CNT_W-1:0];
                open_section(len == 0 ? SEC_HASH : SEC_PAYLOAD);
            end
        end else if (cur_sec == SEC_HASH) begin
            r.frm_end = 1'b1;
            open_section(SEC_SEQ_HI);
        end else begin
            open_section(t_section'(cur_sec + 3'd1));
        end
        r.sec_end = last;
        return r;
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        if (want !== got) begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: predicts on each input transaction and checks each result transaction
    always @(posedge i_clk) begin
        t_byte_tag exp_tag;
        in_fire  <= i_rst_n && i_valid && !o_stall;
        out_fire <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && i_valid && !o_stall)
            tag_q.push_back(deframe_byte(i_data_byte));
        if (i_rst_n && o_valid && !i_stall) begin
            if (tag_q.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: result transaction with nothing expected, section %0d offset %0d",
                             $time, o_section, o_byte_offset);
                errors++;
            end else begin
                exp_tag = tag_q.pop_front();
                check_field("section", exp_tag.section, o_section);
                check_field("byte_offset", exp_tag.offset, o_byte_offset);
                check_field("byte_out", exp_tag.data, o_byte_out);
                check_field("section_end", exp_tag.sec_end, o_section_end);
                check_field("frame_end", exp_tag.frm_end, o_frame_end);
                check_field("length_error", exp_tag.len_err, o_length_error);
                check_field("field_value", exp_tag.value, o_field_value);
                checked++;
                if (exp_tag.frm_end) frames_seen++;
                if (exp_tag.len_err) len_errs++;
            end
        end
    end

    // driver: bursts of random length with random gaps; pace 0 runs without gaps
    int burst_left = 1;
    int gap_left   = 0;
    int pace       = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (gap_left != 0 || stream_q.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left != 0) gap_left <= gap_left - 1;
            end else begin
                i_valid     <= 1'b1;
                i_data_byte <= stream_q.pop_front();
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= (pace == 0) ? 0 : $urandom_range(1, pace == 1 ? 3 : 12);
                    if ($urandom_range(0, 7) == 0) pace <= $urandom_range(0, 2);
                end
            end
        end
    end

    // receiver stall: a rotating 32-bit pattern, reloaded at a random density whenever the 6-bit counter wraps
    logic [31:0] stall_pat = '0;
    logic [5:0]  stall_cnt = '0;

    always @(negedge i_clk) begin
        logic [31:0] fresh;
        case ($urandom_range(0, 3))
            0:       fresh = '0;
            1:       fresh = $urandom & $urandom & $urandom;
            2:       fresh = $urandom;
            default: fresh = $urandom | $urandom;
        endcase
        stall_cnt <= stall_cnt + 1'b1;
        if (stall_cnt == 0) stall_pat <= fresh;
        else                stall_pat <= {stall_pat[0], stall_pat[31:1]};
        i_stall <= stall_pat[0];
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin
        if (in_fire || out_fire) idle_cycles <= 0;
        else                     idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, tag_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_fill(int n, int fill);
        for (int k = 0; k < n; k++) begin
            stream_q.push_back(fill < 0 ? BYTE_W'($urandom) : BYTE_W'(fill));
            queued++;
        end
    endtask

    // whole message; stops after the length section when the length is over the limit
    task automatic send_frame(logic [LEN_W-1:0] len, int fill);
        push_fill(2 * SEQ_BYTES + TYPE_BYTES + 2 * KEY_LEN, fill);
        for (int k = 0; k < 4; k++) begin
            stream_q.push_back(len[8*k +: 8]);
            queued++;
        end
        if (len <= LEN_W'(eff_limit())) begin
            push_fill(int'(len), fill);
            push_fill(KEY_LEN, fill);
        end
    endtask

    // wait until every byte has gone in and every result has come out
    task automatic drain();
        while (stream_q.size() != 0 || i_valid || tag_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        limit_reg   = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        settings++;
    endtask

    // after stray bytes, finish whatever message the parser is in; zero length bytes
    // keep the length small so the payload stays short or the length is refused
    task automatic realign();
        drain();
        while (!(cur_sec == SEC_SEQ_HI && taken == 0)) begin
            if (cur_sec == SEC_LENGTH) push_fill(int'(LEN_BYTES - taken), 0);
            else                       push_fill(int'(section_bytes(cur_sec) - taken), -1);
            drain();
        end
    endtask

    // stimulus
    initial begin
        int               kind;
        logic [LIMIT_W-1:0] lim;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme byte values, zero length, refused lengths, limit edges
        send_frame(0, 255);
        send_frame(3, 0);
        send_frame(MAX_LEN + 1, -1);
        set_limit('0);
        send_frame(1, -1);
        // all-ones limit saturates at the maximum payload
        set_limit({LIMIT_W{1'b1}});
        send_frame(MAX_LEN + 1, -1);
        set_limit(LIMIT_W'(5));
        send_frame(5, -1);

        // random: mostly well-formed messages, some refused lengths and stray bytes
        while (queued < TOTAL_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0:       lim = '0;
                    1:       lim = {LIMIT_W{1'b1}};
                    2:       lim = LIMIT_DEFAULT;
                    3:       lim = LIMIT_W'($urandom_range(1, 64));
                    4:       lim = LIMIT_W'($urandom_range(0, 8191));
                    default: lim = LIMIT_W'($urandom_range(4090, 4102));
                endcase
                set_limit(lim);
            end
            lim  = eff_limit();
            kind = $urandom_range(0, 19);
            if (kind < 2)
                send_frame(0, -1);
            else if (kind < 12)
                send_frame(lim == 0 ? 0 : $urandom_range(1, lim < 24 ? lim : 24), -1);
            else if (kind < 14)
                send_frame(lim <= 48 ? LEN_W'(lim) : $urandom_range(25, 48), -1);
            else if (kind < 16)
                send_frame(LEN_W'(lim) + 1, -1);
            else if (kind < 18)
                send_frame($urandom | 32'h0000_2000, -1);
            else begin
                push_fill($urandom_range(1, 40), -1);
                realign();
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("covered %0d bytes checked, %0d complete messages, %0d refused lengths",
                 checked, frames_seen, len_errs);
        $display("across %0d payload limit settings, %0d mismatches", settings, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/mfd_pkg.sv
src/message_frame_deframer_top.sv
tb/tb.sv
